@@ hdl/held_priority_ltp_claim_arbiter_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the claim arbiter
// Implication checks sampled on the rising clock edge, off during reset.
// ----------------------------------------------------------------------------
`ifndef HELD_PRIORITY_LTP_CLAIM_ARBITER_MACROS_SVH
`define HELD_PRIORITY_LTP_CLAIM_ARBITER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HPLTP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define HPLTP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/hpltp_pkg.sv @@
// ----------------------------------------------------------------------------
// Claim arbiter package
// Shared types, codes and default sizes of the claim arbiter.
// ----------------------------------------------------------------------------
package hpltp_pkg;

	localparam int MAX_CLAIMS_DEF = 16;
	localparam int ID_BITS_DEF    = 32;

	typedef enum logic [1:0] {
		ACT_QUERY   = 2'd0,
		ACT_PUSH    = 2'd1,
		ACT_REMOVE  = 2'd2,
		ACT_RELEASE = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_APPEND,
		ST_RESULT
	} state_t;

	typedef struct packed {
		logic [8:0] count;
		logic [7:0] index;
		logic [1:0] component;
		logic       has_source;
		logic [7:0] param;
		logic [7:0] patch;
	} payload_t;

	localparam int PAY_W = $bits(payload_t);

	typedef struct packed {
		logic load;
		logic proc;
		logic append;
		logic finish;
	} ctl_t;

endpackage

@@ hdl/hpltp_claim_ram.sv @@
// ----------------------------------------------------------------------------
// Claim table memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module hpltp_claim_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 69
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata_q
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

endmodule

@@ hdl/hpltp_seq.sv @@
// ----------------------------------------------------------------------------
// Claim arbiter sequencer
// Walks the live part of the table once per item and steps the datapath.
// ----------------------------------------------------------------------------
module hpltp_seq
	import hpltp_pkg::*;
#(
	parameter int MAX_CLAIMS = MAX_CLAIMS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              item_valid,
	output logic                              item_ready,
	input  logic [$clog2(MAX_CLAIMS+1)-1:0]   live_n,
	input  logic                              out_free,
	output logic [$clog2(MAX_CLAIMS)-1:0]     raddr,
	output ctl_t                              ctl
);

	localparam int IDX_W = $clog2(MAX_CLAIMS);
	localparam int CNT_W = $clog2(MAX_CLAIMS + 1);

	state_t             state_q;
	state_t             state_nxt;
	logic [CNT_W-1:0]   rd_q;
	logic               rdv_s1;
	logic               issue;

	assign issue = (state_q == ST_SCAN) && (rd_q < live_n);
	assign raddr = rd_q[IDX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rd_q    <= '0;
			rdv_s1  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			rdv_s1  <= issue;
			if (state_q == ST_IDLE) begin
				rd_q <= '0;
			end else if (issue) begin
				rd_q <= rd_q + CNT_W'(1);
			end
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid) state_nxt = ST_SCAN;
			end
			ST_SCAN: begin
				if (!issue && !rdv_s1) state_nxt = ST_APPEND;
			end
			ST_APPEND: begin
				state_nxt = ST_RESULT;
			end
			ST_RESULT: begin
				if (out_free) state_nxt = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		item_ready = (state_q == ST_IDLE);
		ctl.load   = item_valid && (state_q == ST_IDLE);
		ctl.proc   = rdv_s1;
		ctl.append = (state_q == ST_APPEND);
		ctl.finish = (state_q == ST_RESULT) && out_free;
	end

endmodule

@@ hdl/hpltp_datapath.sv @@
// ----------------------------------------------------------------------------
// Claim arbiter datapath
// Compacts the table entry by entry, tracks the winner and holds the result.
// ----------------------------------------------------------------------------
module hpltp_datapath
	import hpltp_pkg::*;
#(
	parameter int MAX_CLAIMS = MAX_CLAIMS_DEF,
	parameter int ID_BITS    = ID_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  ctl_t                                ctl,
	input  logic [1:0]                          action,
	input  logic [31:0]                         claim_id,
	input  logic [7:0]                          patch_ref,
	input  logic [7:0]                          param_ref,
	input  logic                                has_source,
	input  logic [1:0]                          component_sel,
	input  logic [7:0]                          source_index,
	input  logic [8:0]                          source_count,
	input  logic                                is_held,
	input  logic [ID_BITS+PAY_W:0]              rdata,
	output logic                                we,
	output logic [$clog2(MAX_CLAIMS)-1:0]       waddr,
	output logic [ID_BITS+PAY_W:0]              wdata,
	output logic [$clog2(MAX_CLAIMS+1)-1:0]     live_n,
	output logic                                out_free,
	output logic                                result_valid,
	input  logic                                result_ready,
	output logic                                use_claim,
	output logic                                winner_present,
	output logic [31:0]                         winner_id,
	output logic                                winner_held,
	output logic [7:0]                          win_patch,
	output logic [7:0]                          win_param,
	output logic [1:0]                          win_component,
	output logic [7:0]                          win_index,
	output logic [8:0]                          win_count,
	output logic                                push_dropped
);

	localparam int IDX_W  = $clog2(MAX_CLAIMS);
	localparam int CNT_W  = $clog2(MAX_CLAIMS + 1);
	localparam int WORD_W = 1 + ID_BITS + PAY_W;

	action_t             act_q;
	logic [ID_BITS-1:0]  id_q;
	payload_t            pay_q;
	logic                hold_q;
	logic [CNT_W-1:0]    w_q;
	logic [CNT_W-1:0]    n_q;
	logic                hfound_q;
	logic                drop_q;
	logic [WORD_W-1:0]   last_q;
	logic [WORD_W-1:0]   hwin_q;
	logic                out_valid_q;

	logic                match;
	logic                kill;
	logic                keep_held;
	logic [WORD_W-1:0]   kept_word;
	logic [WORD_W-1:0]   new_word;
	logic                room;
	logic                can_push;
	logic                keep;
	logic [WORD_W-1:0]   res_word;
	logic                res_any;
	payload_t            res_pay;

	assign match     = (rdata[PAY_W +: ID_BITS] == id_q);
	assign kill      = match && ((act_q == ACT_PUSH) || (act_q == ACT_REMOVE));
	assign keep_held = rdata[WORD_W-1] && !(match && (act_q == ACT_RELEASE));
	assign kept_word = {keep_held, rdata[WORD_W-2:0]};
	assign new_word  = {hold_q, id_q, pay_q};
	assign room      = (w_q != CNT_W'(MAX_CLAIMS));
	assign can_push  = (act_q == ACT_PUSH) && room;
	assign keep      = ctl.proc && !kill;

	assign we     = keep || (ctl.append && can_push);
	assign waddr  = w_q[IDX_W-1:0];
	assign wdata  = ctl.proc ? kept_word : new_word;
	assign live_n = n_q;

	assign res_word = hfound_q ? hwin_q : last_q;
	assign res_any  = hfound_q || (n_q != '0);
	assign res_pay  = payload_t'(res_word[PAY_W-1:0]);

	assign out_free     = !out_valid_q || result_ready;
	assign result_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q         <= '0;
			n_q         <= '0;
			hfound_q    <= 1'b0;
			drop_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.load) begin
				w_q      <= '0;
				hfound_q <= 1'b0;
				drop_q   <= 1'b0;
			end else if (keep) begin
				w_q <= w_q + CNT_W'(1);
				if (keep_held) hfound_q <= 1'b1;
			end else if (ctl.append) begin
				if (can_push) begin
					n_q <= w_q + CNT_W'(1);
					if (hold_q) hfound_q <= 1'b1;
				end else begin
					n_q <= w_q;
				end
				drop_q <= (act_q == ACT_PUSH) && !room;
			end
			if (ctl.finish) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			act_q  <= action_t'(action);
			id_q   <= ID_BITS'(claim_id);
			pay_q  <= '{count: source_count, index: source_index, component: component_sel,
				has_source: has_source, param: param_ref, patch: patch_ref};
			hold_q <= is_held;
		end
		if (keep) begin
			last_q <= kept_word;
			if (keep_held) hwin_q <= kept_word;
		end else if (ctl.append && can_push) begin
			last_q <= new_word;
			if (hold_q) hwin_q <= new_word;
		end
		if (ctl.finish) begin
			use_claim      <= res_any && res_pay.has_source;
			winner_present <= res_any;
			winner_id      <= res_any ? 32'(res_word[PAY_W +: ID_BITS]) : '0;
			winner_held    <= res_any && res_word[WORD_W-1];
			win_patch      <= res_any ? res_pay.patch : '0;
			win_param      <= res_any ? res_pay.param : '0;
			win_component  <= res_any ? res_pay.component : '0;
			win_index      <= res_any ? res_pay.index : '0;
			win_count      <= res_any ? res_pay.count : '0;
			push_dropped   <= drop_q;
		end
	end

endmodule

@@ hdl/held_priority_ltp_claim_arbiter.sv @@
// ----------------------------------------------------------------------------
// Held-priority latest-takes-precedence claim arbiter
// Claim table for one lighting channel with push, remove, release and query.
// ----------------------------------------------------------------------------
// The item channel (item_valid/item_ready) carries one action per beat. The
// block takes a beat only when idle, then walks the n live claims of the
// table through a single compare unit, one claim per cycle, compacting the
// table in memory and tracking the newest held and newest claim on the way.
// A push appends its claim in the append step after the walk, or is dropped
// when the table is full. The result step then fills the output register:
// the result beat appears on result_valid/result_ready and the block goes
// back to idle for the next item, so no item is taken before the last one
// is done. The walk over the memory read port sets how long an item takes.
// The result sits in an output register; a stalled receiver holds the block
// in its last step until that register is free, and the result stays
// unchanged meanwhile.
// Reset empties the table at once through the live count; the claim memory
// itself is not cleared, and no entry beyond the count is ever used.
// ----------------------------------------------------------------------------
module held_priority_ltp_claim_arbiter
	import hpltp_pkg::*;
#(
	parameter int MAX_CLAIMS = MAX_CLAIMS_DEF,
	parameter int ID_BITS    = ID_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic [1:0]  action,
	input  logic [31:0] claim_id,
	input  logic [7:0]  patch_ref,
	input  logic [7:0]  param_ref,
	input  logic        has_source,
	input  logic [1:0]  component_sel,
	input  logic [7:0]  source_index,
	input  logic [8:0]  source_count,
	input  logic        is_held,
	output logic        result_valid,
	input  logic        result_ready,
	output logic        use_claim,
	output logic        winner_present,
	output logic [31:0] winner_id,
	output logic        winner_held,
	output logic [7:0]  win_patch,
	output logic [7:0]  win_param,
	output logic [1:0]  win_component,
	output logic [7:0]  win_index,
	output logic [8:0]  win_count,
	output logic        push_dropped
);

	localparam int IDX_W  = $clog2(MAX_CLAIMS);
	localparam int CNT_W  = $clog2(MAX_CLAIMS + 1);
	localparam int WORD_W = 1 + ID_BITS + PAY_W;

	ctl_t              ctl;
	logic [CNT_W-1:0]  live_n;
	logic              out_free;
	logic [IDX_W-1:0]  raddr;
	logic [IDX_W-1:0]  waddr;
	logic              we;
	logic [WORD_W-1:0] wdata;
	logic [WORD_W-1:0] rdata;

	hpltp_claim_ram #(
		.DEPTH (MAX_CLAIMS),
		.WIDTH (WORD_W)
	) u_ram (
		.clk     (clk),
		.we      (we),
		.waddr   (waddr),
		.wdata   (wdata),
		.raddr   (raddr),
		.rdata_q (rdata)
	);

	hpltp_seq #(
		.MAX_CLAIMS (MAX_CLAIMS)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.live_n     (live_n),
		.out_free   (out_free),
		.raddr      (raddr),
		.ctl        (ctl)
	);

	hpltp_datapath #(
		.MAX_CLAIMS (MAX_CLAIMS),
		.ID_BITS    (ID_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctl            (ctl),
		.action         (action),
		.claim_id       (claim_id),
		.patch_ref      (patch_ref),
		.param_ref      (param_ref),
		.has_source     (has_source),
		.component_sel  (component_sel),
		.source_index   (source_index),
		.source_count   (source_count),
		.is_held        (is_held),
		.rdata          (rdata),
		.we             (we),
		.waddr          (waddr),
		.wdata          (wdata),
		.live_n         (live_n),
		.out_free       (out_free),
		.result_valid   (result_valid),
		.result_ready   (result_ready),
		.use_claim      (use_claim),
		.winner_present (winner_present),
		.winner_id      (winner_id),
		.winner_held    (winner_held),
		.win_patch      (win_patch),
		.win_param      (win_param),
		.win_component  (win_component),
		.win_index      (win_index),
		.win_count      (win_count),
		.push_dropped   (push_dropped)
	);

endmodule

@@ hdl/hpltp_checker.sv @@
// ----------------------------------------------------------------------------
// Claim arbiter port checker
// Watches the top-level ports of the claim arbiter over time.
// ----------------------------------------------------------------------------
`include "held_priority_ltp_claim_arbiter_macros.svh"

module hpltp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        item_valid,
	input logic        item_ready,
	input logic        result_valid,
	input logic        result_ready,
	input logic        use_claim,
	input logic        winner_present,
	input logic [31:0] winner_id,
	input logic        winner_held
);

	`HPLTP_ASSERT_NEXT(a_result_holds, clk, arst_n, result_valid && !result_ready, result_valid, "result beat withdrawn before it was taken")

	`HPLTP_ASSERT_NEXT(a_busy_after_item, clk, arst_n, item_valid && item_ready, !item_ready, "block took a second item while still working")

	`HPLTP_ASSERT_SAME(a_use_needs_winner, clk, arst_n, result_valid && (use_claim || winner_held), winner_present, "claim used or held without a winner")

	`HPLTP_ASSERT_SAME(a_no_winner_zero_id, clk, arst_n, result_valid && !winner_present, winner_id == 32'd0, "winner id not zero with no winner")

endmodule

bind held_priority_ltp_claim_arbiter hpltp_checker u_hpltp_checker (.*);

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// Claim arbiter testbench
// Drives claim beats into the arbiter through a short directed table and a
// long random run of push, remove, release and query phases. Every result
// beat is checked field by field against a claim table model kept here, or
// a directed row's typed outcome. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import hpltp_pkg::*;

	localparam int RAND_ITEMS  = 1850;
	localparam int CYCLE_LIMIT = 600000;
	localparam int IDLE_PCT    = 28;

	typedef struct packed {
		logic        use_claim;
		logic        winner_present;
		logic [31:0] winner_id;
		logic        winner_held;
		logic [7:0]  win_patch;
		logic [7:0]  win_param;
		logic [1:0]  win_component;
		logic [7:0]  win_index;
		logic [8:0]  win_count;
		logic        push_dropped;
	} outcome_t;

	typedef struct packed {
		logic     typed;
		outcome_t exp_out;
	} typed_exp_t;

	typedef struct packed {
		action_t     act;
		logic [31:0] id;
		payload_t    pay;
		logic        held;
		logic [4:0]  rep;
		logic        typed;
		outcome_t    exp_out;
	} dir_row_t;

	localparam int DIR_ROWS = 14;

	// Payload order: count, index, component, has_source, param, patch.
	// Outcome order: use, present, id, held, patch, param, component, index,
	// count, dropped.
	dir_row_t dir_rows [0:DIR_ROWS-1] = '{
		'{ACT_QUERY, 32'h0, '0, 1'b0, 5'd1, 1'b1, '0},
		'{ACT_PUSH, 32'h0, '0, 1'b0, 5'd1, 1'b1,
			'{1'b0, 1'b1, 32'h0, 1'b0, 8'h0, 8'h0, 2'h0, 8'h0, 9'h0, 1'b0}},
		'{ACT_PUSH, 32'hFFFF_FFFF, '{9'h1FF, 8'hFF, 2'h3, 1'b1, 8'hFF, 8'hFF},
			1'b1, 5'd1, 1'b1,
			'{1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1, 8'hFF, 8'hFF, 2'h3, 8'hFF, 9'h1FF, 1'b0}},
		'{ACT_PUSH, 32'd5, '{9'd1, 8'd0, 2'd1, 1'b1, 8'd34, 8'd12}, 1'b0, 5'd1,
			1'b0, '0},
		'{ACT_RELEASE, 32'hFFFF_FFFF, '0, 1'b0, 5'd1, 1'b0, '0},
		'{ACT_RELEASE, 32'd77, '0, 1'b1, 5'd1, 1'b0, '0},
		'{ACT_REMOVE, 32'd78, '0, 1'b0, 5'd1, 1'b0, '0},
		'{ACT_PUSH, 32'h0, '{9'd256, 8'd255, 2'd2, 1'b1, 8'd7, 8'd9}, 1'b1, 5'd1,
			1'b0, '0},
		'{ACT_REMOVE, 32'd5, '0, 1'b0, 5'd1, 1'b0, '0},
		'{ACT_REMOVE, 32'h0, '0, 1'b0, 5'd1, 1'b0, '0},
		'{ACT_REMOVE, 32'hFFFF_FFFF, '0, 1'b0, 5'd1, 1'b1, '0},
		'{ACT_PUSH, 32'd100, '{9'd0, 8'd3, 2'd3, 1'b1, 8'd1, 8'd40}, 1'b0, 5'd16,
			1'b0, '0},
		'{ACT_PUSH, 32'd103, '{9'd2, 8'd9, 2'd0, 1'b0, 8'd90, 8'd91}, 1'b1, 5'd1,
			1'b0, '0},
		'{ACT_PUSH, 32'd200, '{9'd3, 8'd1, 2'd1, 1'b1, 8'd5, 8'd6}, 1'b0, 5'd1,
			1'b0, '0}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_ready;
	logic [1:0]  action = '0;
	logic [31:0] claim_id = '0;
	logic [7:0]  patch_ref = '0;
	logic [7:0]  param_ref = '0;
	logic        has_source = 1'b0;
	logic [1:0]  component_sel = '0;
	logic [7:0]  source_index = '0;
	logic [8:0]  source_count = '0;
	logic        is_held = 1'b0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	logic        use_claim;
	logic        winner_present;
	logic [31:0] winner_id;
	logic        winner_held;
	logic [7:0]  win_patch;
	logic [7:0]  win_param;
	logic [1:0]  win_component;
	logic [7:0]  win_index;
	logic [8:0]  win_count;
	logic        push_dropped;

	logic [31:0] claim_ids   [0:MAX_CLAIMS_DEF-1];
	payload_t    claim_pays  [0:MAX_CLAIMS_DEF-1];
	logic        claim_holds [0:MAX_CLAIMS_DEF-1];
	int          live_claims = 0;

	outcome_t    winner_q [$];
	typed_exp_t  typed_q [$];
	int          failures = 0;
	int          beats_sent = 0;
	int          results_seen = 0;
	int          drops_seen = 0;
	int          held_wins = 0;
	int          cycle_count = 0;
	bit          calm = 1'b0;

	held_priority_ltp_claim_arbiter u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.action(action),
		.claim_id(claim_id),
		.patch_ref(patch_ref),
		.param_ref(param_ref),
		.has_source(has_source),
		.component_sel(component_sel),
		.source_index(source_index),
		.source_count(source_count),
		.is_held(is_held),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.use_claim(use_claim),
		.winner_present(winner_present),
		.winner_id(winner_id),
		.winner_held(winner_held),
		.win_patch(win_patch),
		.win_param(win_param),
		.win_component(win_component),
		.win_index(win_index),
		.win_count(win_count),
		.push_dropped(push_dropped)
	);

	always #1 clk = ~clk;

	always @(posedge clk) cycle_count <= cycle_count + 1;

	function automatic void purge_claims(logic [31:0] id);
		int keep;
		keep = 0;
		for (int r = 0; r < live_claims; r++) begin
			if (claim_ids[r] != id) begin
				claim_ids[keep]   = claim_ids[r];
				claim_pays[keep]  = claim_pays[r];
				claim_holds[keep] = claim_holds[r];
				keep++;
			end
		end
		live_claims = keep;
	endfunction

	function automatic outcome_t arbitrate(action_t act, logic [31:0] id, payload_t pay,
			logic held);
		outcome_t res;
		int       win;
		res = '0;
		win = -1;
		case (act)
			ACT_PUSH: begin
				purge_claims(id);
				if (live_claims >= MAX_CLAIMS_DEF) begin
					res.push_dropped = 1'b1;
				end else begin
					claim_ids[live_claims]   = id;
					claim_pays[live_claims]  = pay;
					claim_holds[live_claims] = held;
					live_claims++;
				end
			end
			ACT_REMOVE: purge_claims(id);
			ACT_RELEASE: begin
				for (int i = 0; i < live_claims; i++)
					if (claim_ids[i] == id)
						claim_holds[i] = 1'b0;
			end
			default: ;
		endcase
		for (int i = 0; i < live_claims; i++)
			if (claim_holds[i])
				win = i;
		if (win < 0)
			win = live_claims - 1;
		if (win >= 0) begin
			res.use_claim      = claim_pays[win].has_source;
			res.winner_present = 1'b1;
			res.winner_id      = claim_ids[win];
			res.winner_held    = claim_holds[win];
			res.win_patch      = claim_pays[win].patch;
			res.win_param      = claim_pays[win].param;
			res.win_component  = claim_pays[win].component;
			res.win_index      = claim_pays[win].index;
			res.win_count      = claim_pays[win].count;
		end
		return res;
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			failures++;
		end
	endfunction

	always @(posedge clk) begin : monitor
		outcome_t   want;
		outcome_t   got;
		payload_t   pay;
		typed_exp_t typed_entry;
		if (arst_n && item_valid && item_ready) begin
			pay = '{count: source_count, index: source_index, component: component_sel,
				has_source: has_source, param: param_ref, patch: patch_ref};
			want = arbitrate(action_t'(action), claim_id, pay, is_held);
			typed_entry = typed_q.pop_front();
			if (typed_entry.typed)
				want = typed_entry.exp_out;
			winner_q = {winner_q, want};
		end
		if (arst_n && result_valid && result_ready) begin
			got = '{use_claim, winner_present, winner_id, winner_held, win_patch, win_param,
				win_component, win_index, win_count, push_dropped};
			results_seen++;
			if (winner_q.size() == 0) begin
				$error("result beat with no expected winner pending");
				failures++;
			end else begin
				want = winner_q.pop_front();
				check_field("use_claim", 32'(want.use_claim), 32'(got.use_claim));
				check_field("winner_present", 32'(want.winner_present),
					32'(got.winner_present));
				check_field("winner_id", want.winner_id, got.winner_id);
				check_field("winner_held", 32'(want.winner_held), 32'(got.winner_held));
				check_field("win_patch", 32'(want.win_patch), 32'(got.win_patch));
				check_field("win_param", 32'(want.win_param), 32'(got.win_param));
				check_field("win_component", 32'(want.win_component),
					32'(got.win_component));
				check_field("win_index", 32'(want.win_index), 32'(got.win_index));
				check_field("win_count", 32'(want.win_count), 32'(got.win_count));
				check_field("push_dropped", 32'(want.push_dropped), 32'(got.push_dropped));
				drops_seen += int'(want.push_dropped);
				held_wins += int'(want.winner_held);
			end
		end
	end

	always @(negedge clk)
		result_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);

	task automatic send_claim(action_t act, logic [31:0] id, payload_t pay, logic held,
			logic typed, outcome_t exp_out);
		if (beats_sent == 400 || beats_sent == 1300) begin
			item_valid <= 1'b0;
			@(negedge clk);
			while (winner_q.size() != 0)
				@(negedge clk);
		end
		while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		typed_q = {typed_q, typed_exp_t'{typed, exp_out}};
		item_valid    <= 1'b1;
		action        <= act;
		claim_id      <= id;
		patch_ref     <= pay.patch;
		param_ref     <= pay.param;
		has_source    <= pay.has_source;
		component_sel <= pay.component;
		source_index  <= pay.index;
		source_count  <= pay.count;
		is_held       <= held;
		do
			@(posedge clk);
		while (!item_ready);
		beats_sent++;
		calm = (beats_sent >= 700 && beats_sent < 1000);
		@(negedge clk);
	endtask

	initial begin : stimulus
		logic [31:0] base;
		logic [31:0] id;
		payload_t    pay;
		action_t     act;
		int          phase_len;
		int          push_pct;
		int          remove_pct;
		int          roll;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		foreach (dir_rows[r]) begin
			for (int k = 0; k < dir_rows[r].rep; k++) begin
				pay = dir_rows[r].pay;
				pay.patch = pay.patch + 8'(k);
				send_claim(dir_rows[r].act, dir_rows[r].id + k, pay, dir_rows[r].held,
					dir_rows[r].typed, dir_rows[r].exp_out);
			end
		end
		while (beats_sent < RAND_ITEMS) begin
			base       = $urandom;
			phase_len  = $urandom_range(20, 80);
			push_pct   = $urandom_range(15, 70);
			remove_pct = $urandom_range(5, 40);
			for (int k = 0; k < phase_len && beats_sent < RAND_ITEMS; k++) begin
				roll = $urandom_range(0, 99);
				if (roll < push_pct)
					act = ACT_PUSH;
				else if (roll < push_pct + remove_pct)
					act = ACT_REMOVE;
				else if (roll < push_pct + remove_pct + 15)
					act = ACT_RELEASE;
				else
					act = ACT_QUERY;
				if ($urandom_range(0, 99) < 8)
					id = $urandom;
				else
					id = base + $urandom_range(0, 19);
				pay = payload_t'(36'({$urandom, $urandom}));
				send_claim(act, id, pay, 1'($urandom_range(0, 1)), 1'b0, '0);
			end
		end
		item_valid <= 1'b0;
		while (winner_q.size() != 0)
			@(posedge clk);
		repeat (MAX_CLAIMS_DEF + 10) @(posedge clk);
		if (winner_q.size() != 0) begin
			$error("%0d expected winners never arrived", winner_q.size());
			failures++;
		end
		$display("tb: ran %0d claim beats, %0d result beats checked", beats_sent, results_seen);
		$display("tb: %0d pushes dropped on a full table, %0d held winners", drops_seen,
			held_wins);
		if (failures == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	initial begin : watchdog
		wait (cycle_count >= CYCLE_LIMIT);
		$display("tb: failure");
		$finish;
	end

endmodule
